// ----- src/kmrg_pkg.sv -----
`timescale 1ns / 1ps

package kmrg_pkg;

    localparam int KEY_W      = 5;

    localparam logic [1:0] OP_KEYBOARD = 2'd0;
    localparam logic [1:0] OP_SERIAL   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [KEY_W-1:0] KEY_NONE   = 5'b00000;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 5'b00001;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 5'b00010;
    localparam logic [KEY_W-1:0] KEY_UP     = 5'b00100;
    localparam logic [KEY_W-1:0] KEY_LEFT   = 5'b01000;
    localparam logic [KEY_W-1:0] KEY_SELECT = 5'b10000;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] buttons_raw;
        logic [7:0] serial_byte;
        logic       serial_has_byte;
        logic       serial_error;
        logic       extended_code;
        logic       key_released;
        logic [7:0] scan_code;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0] pressed_keys;
        logic [KEY_W-1:0] held_keys;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0] set_mask;
        logic [KEY_W-1:0] clr_mask;
    } serial_cmd_t;

    function automatic logic [KEY_W-1:0] scan_to_key(input logic [7:0] code,
                                                     input logic ext);
        logic [KEY_W-1:0] key;
        key = KEY_NONE;
        if (!ext) begin
            case (code)
                8'h1D: key = KEY_UP;
                8'h1B: key = KEY_DOWN;
                8'h1C: key = KEY_LEFT;
                8'h23: key = KEY_RIGHT;
                8'h29, 8'h2C, 8'h2B, 8'h4B, 8'h5A: key = KEY_SELECT;
                default: key = KEY_NONE;
            endcase
        end else begin
            case (code)
                8'h75: key = KEY_UP;
                8'h72: key = KEY_DOWN;
                8'h6B: key = KEY_LEFT;
                8'h74: key = KEY_RIGHT;
                default: key = KEY_NONE;
            endcase
        end
        return key;
    endfunction

    function automatic serial_cmd_t serial_decode(input logic [7:0] ch);
        serial_cmd_t cmd;
        cmd.set_mask = KEY_NONE;
        cmd.clr_mask = KEY_NONE;
        case (ch)
            8'h55: cmd.set_mask = KEY_UP;
            8'h75: cmd.clr_mask = KEY_UP;
            8'h44: cmd.set_mask = KEY_DOWN;
            8'h64: cmd.clr_mask = KEY_DOWN;
            8'h52: cmd.set_mask = KEY_RIGHT;
            8'h72: cmd.clr_mask = KEY_RIGHT;
            8'h4C, 8'h54, 8'h46: cmd.set_mask = KEY_SELECT;
            8'h6C, 8'h74, 8'h66: cmd.clr_mask = KEY_SELECT;
            default: cmd.set_mask = KEY_NONE;
        endcase
        return cmd;
    endfunction

    function automatic logic [KEY_W-1:0] buttons_to_key(input logic [3:0] raw);
        logic [3:0]       p;
        logic [KEY_W-1:0] key;
        p   = ~raw;
        key = KEY_NONE;
        if (p[3]) key = key | KEY_UP;
        if (p[0]) key = key | KEY_DOWN;
        if (p[2]) key = key | KEY_LEFT;
        if (p[1]) key = key | KEY_RIGHT;
        return key;
    endfunction

endpackage

// ----- src/kmrg_in_skid.sv -----
`timescale 1ns / 1ps

module kmrg_in_skid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  kmrg_pkg::item_t  in_item,
    output logic             item_valid,
    input  logic             item_ready,
    output kmrg_pkg::item_t  item
);

    logic            main_valid_reg, main_valid_next;
    logic            skid_valid_reg, skid_valid_next;
    kmrg_pkg::item_t main_item_reg, main_item_next;
    kmrg_pkg::item_t skid_item_reg, skid_item_next;
    logic            take_in;
    logic            take_out;

    assign in_ready   = !skid_valid_reg;
    assign item_valid = main_valid_reg;
    assign item       = main_item_reg;
    assign take_in    = in_valid && !skid_valid_reg;
    assign take_out   = main_valid_reg && item_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_item_next  = main_item_reg;
        skid_item_next  = skid_item_reg;
        if (take_out) begin
            if (skid_valid_reg) begin
                main_item_next  = skid_item_reg;
                skid_valid_next = 1'b0;
            end else if (take_in) begin
                main_item_next = in_item;
            end else begin
                main_valid_next = 1'b0;
            end
        end else if (take_in) begin
            if (!main_valid_reg) begin
                main_item_next  = in_item;
                main_valid_next = 1'b1;
            end else begin
                skid_item_next  = in_item;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_item_reg <= main_item_next;
        skid_item_reg <= skid_item_next;
    end

endmodule

// ----- src/kmrg_core.sv -----
`timescale 1ns / 1ps

module kmrg_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    output logic              item_ready,
    input  kmrg_pkg::item_t   item,
    input  logic              res_ready,
    output logic              res_valid,
    output kmrg_pkg::result_t res
);

    logic [kmrg_pkg::KEY_W-1:0] kbd_mask_reg, kbd_mask_next;
    logic [kmrg_pkg::KEY_W-1:0] ser_mask_reg, ser_mask_next;
    logic [kmrg_pkg::KEY_W-1:0] held_reg, held_next;
    logic [kmrg_pkg::KEY_W-1:0] pressed_reg, pressed_next;
    logic [kmrg_pkg::KEY_W-1:0] kbd_key;
    logic [kmrg_pkg::KEY_W-1:0] btn_key;
    logic [kmrg_pkg::KEY_W-1:0] ser_base;
    logic [kmrg_pkg::KEY_W-1:0] tick_pressed;
    kmrg_pkg::serial_cmd_t      cmd;
    logic                       is_tick;
    logic                       advance;

    assign is_tick    = (item.operation == kmrg_pkg::OP_TICK);
    assign item_ready = !is_tick || res_ready;
    assign advance    = item_valid && item_ready;

    assign kbd_key      = kmrg_pkg::scan_to_key(item.scan_code, item.extended_code);
    assign btn_key      = kmrg_pkg::buttons_to_key(item.buttons_raw);
    assign cmd          = kmrg_pkg::serial_decode(item.serial_byte);
    assign ser_base     = item.serial_error ? kmrg_pkg::KEY_NONE : ser_mask_reg;
    assign tick_pressed = pressed_reg | (btn_key & ~held_reg);

    assign res_valid        = advance && is_tick;
    assign res.held_keys    = kbd_mask_reg | ser_mask_reg | btn_key;
    assign res.pressed_keys = tick_pressed;

    always_comb begin
        kbd_mask_next = kbd_mask_reg;
        ser_mask_next = ser_mask_reg;
        held_next     = held_reg;
        pressed_next  = pressed_reg;
        if (advance) begin
            case (item.operation)
                kmrg_pkg::OP_KEYBOARD: begin
                    if (item.key_released) begin
                        kbd_mask_next = kbd_mask_reg & ~kbd_key;
                    end else begin
                        kbd_mask_next = kbd_mask_reg | kbd_key;
                        if ((held_reg & kbd_key) == kmrg_pkg::KEY_NONE) begin
                            pressed_next = pressed_reg | kbd_key;
                        end
                    end
                end
                kmrg_pkg::OP_SERIAL: begin
                    if (item.serial_has_byte) begin
                        ser_mask_next = (ser_base | cmd.set_mask) & ~cmd.clr_mask;
                        pressed_next  = pressed_reg | cmd.set_mask;
                    end else begin
                        ser_mask_next = ser_base;
                    end
                end
                kmrg_pkg::OP_TICK: begin
                    held_next    = res.held_keys;
                    pressed_next = kmrg_pkg::KEY_NONE;
                end
                default: begin
                    held_next = held_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kbd_mask_reg <= '0;
            ser_mask_reg <= '0;
            held_reg     <= '0;
            pressed_reg  <= '0;
        end else begin
            kbd_mask_reg <= kbd_mask_next;
            ser_mask_reg <= ser_mask_next;
            held_reg     <= held_next;
            pressed_reg  <= pressed_next;
        end
    end

endmodule

// ----- src/kmrg_out_reg.sv -----
`timescale 1ns / 1ps

module kmrg_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_ready,
    input  kmrg_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_ready,
    output kmrg_pkg::result_t out_res
);

    logic              valid_reg, valid_next;
    kmrg_pkg::result_t res_reg, res_next;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (res_ready) begin
            valid_next = res_valid;
            if (res_valid) begin
                res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

endmodule

// ----- src/multi_source_key_merger.sv -----
`timescale 1ns / 1ps

// Merges keyboard scan events, serial command bytes and push-button ticks into a five-bit held
// mask and a pressed mask (bit 0 right, bit 1 down, bit 2 up, bit 3 left, bit 4 select). One
// transaction is accepted every cycle unless a waiting result holds the flow; keyboard and
// serial transactions only update internal state, while each tick transaction yields exactly
// one result transaction, carried from the input skid register through the update logic into
// the output register. Operation code three is ignored. Throughput stays at one transaction
// per cycle as long as the result side keeps m_tready high; while a result waits, the next
// tick is held in the update logic and every transaction behind it waits as well.

module multi_source_key_merger (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // scan_code[7:0], key_released[8], extended_code[9], serial_error[10],
    // serial_has_byte[11], serial_byte[19:12], buttons_raw[23:20]
    input  logic [23:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // held_keys[4:0], pressed_keys[9:5], zero padding[15:10]
    output logic [15:0] m_tdata
);

    kmrg_pkg::item_t   in_item;
    kmrg_pkg::item_t   item;
    kmrg_pkg::result_t res;
    kmrg_pkg::result_t out_res;
    logic              item_valid;
    logic              item_ready;
    logic              res_valid;
    logic              res_ready;

    assign in_item.operation       = s_tuser;
    assign in_item.scan_code       = s_tdata[7:0];
    assign in_item.key_released    = s_tdata[8];
    assign in_item.extended_code   = s_tdata[9];
    assign in_item.serial_error    = s_tdata[10];
    assign in_item.serial_has_byte = s_tdata[11];
    assign in_item.serial_byte     = s_tdata[19:12];
    assign in_item.buttons_raw     = s_tdata[23:20];

    kmrg_in_skid u_in_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    kmrg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    kmrg_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'b000000, out_res.pressed_keys, out_res.held_keys};

endmodule

// ----- src/kmrg_checker.sv -----
`timescale 1ns / 1ps

module kmrg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // The block comes out of reset empty and ready to take a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (!m_tvalid && s_tready))
        else $error("block not empty after reset");

    // A stalled result transaction keeps its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result transaction changed");

    // The input side can only stop accepting after it has taken a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("s_tready fell without an accepted transaction");

    // The padding bits of a result are always zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:10] == 6'b000000))
        else $error("result padding bits not zero");

endmodule

bind multi_source_key_merger kmrg_checker u_kmrg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
